// ===== rtl/core/lcer_pkg.sv =====
// Shared types and constants for the LED current exposure regulator.
// No dependencies.
package lcer_pkg;

    localparam logic [7:0] TOUCH_PRESENT = 8'h80;
    localparam logic [7:0] LED_DRIVE_BASE = 8'hE0;
    localparam logic [7:0] LED_RELEASED = 8'hFF;

    // regulator phase codes; the unused code behaves as lowering
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RAISE = 2'd1;
    localparam logic [1:0] PH_LOWER = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_LIMIT = 3'd0;
    localparam logic [2:0] CFG_START_HIGH = 3'd1;
    localparam logic [2:0] CFG_START_LOW = 3'd2;
    localparam logic [2:0] CFG_KEEP_HIGH = 3'd3;
    localparam logic [2:0] CFG_KEEP_LOW = 3'd4;
    localparam logic [2:0] CFG_CUR_HIGH = 3'd5;
    localparam logic [2:0] CFG_CUR_LOW = 3'd6;
    localparam logic [2:0] CFG_STEP_INC = 3'd7;

    typedef struct packed {
        logic       sensor_active;
        logic       current_changed;
        logic [7:0] led_value;
        logic       led_write;
    } t_result;

endpackage

// ===== rtl/core/led_current_exposure_regulator.sv =====
// LED current exposure regulator: top level, single register stage.
// Depends on lcer_pkg.
//
// One frame event per item. Each item is decided in the cycle it is accepted
// against the current regulator state, and its result lands in the output
// register the next cycle, so the block sustains one item per clock; the
// input is ready whenever the output register is empty or being drained.
// Configuration registers take effect for the next accepted item; the
// configuration port is always ready.
module led_current_exposure_regulator #(
    parameter logic [4:0] DEFAULT_STEP = 5'd8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    // frame events in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] touch_code, [17:8] exposure_lines, rest zero
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] led_write, [8:1] led_value,
                                        // [9] current_changed, [10] sensor_active, rest zero
);

    // configuration
    logic [7:0] r_frame_limit;
    logic [9:0] r_start_high, r_start_low, r_keep_high, r_keep_low;
    logic [4:0] r_cur_high, r_cur_low, r_step_inc;

    // regulator state
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_frame_cnt, n_frame_cnt;
    logic [5:0] r_step, n_step;
    logic       r_asleep, n_asleep;

    // output register
    logic                 r_out_valid;
    lcer_pkg::t_result    r_out, n_out;

    logic [7:0] touch;
    logic [9:0] expo;
    logic       accept;
    logic [6:0] step_up, lo_plus, step_dn, hi_ext, lo_ext, cur;
    logic       changed;

    assign touch  = s_axis_tdata[7:0];
    assign expo   = s_axis_tdata[17:8];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    always_comb begin
        n_phase     = r_phase;
        n_frame_cnt = r_frame_cnt;
        n_step      = r_step;
        n_asleep    = r_asleep;
        n_out       = '0;
        changed     = 1'b0;
        hi_ext      = {2'd0, r_cur_high};
        lo_ext      = {2'd0, r_cur_low};
        lo_plus     = lo_ext + {2'd0, r_step_inc};
        cur         = {1'b0, r_step};
        step_up     = 7'd0;
        step_dn     = 7'd0;

        if (touch == lcer_pkg::TOUCH_PRESENT) begin
            n_out.sensor_active = 1'b1;
            if (r_asleep) begin
                n_out.led_write = 1'b1;
                n_out.led_value = lcer_pkg::LED_DRIVE_BASE | {3'd0, DEFAULT_STEP};
                n_asleep        = 1'b0;
            end
            if (r_frame_cnt <= r_frame_limit) begin
                n_frame_cnt = r_frame_cnt + 8'd1;
            end else begin
                n_frame_cnt = 8'd0;
                // idle decision reads the step back through the 5-bit register field
                if (r_phase == lcer_pkg::PH_IDLE) begin
                    cur = {2'd0, r_step[4:0]};
                end
                step_up = cur + {2'd0, r_step_inc};
                step_dn = cur - {2'd0, r_step_inc};
                case (r_phase)
                    lcer_pkg::PH_IDLE: begin
                        if (expo >= r_start_high || expo <= r_start_low) begin
                            n_step = cur[5:0];
                            if (expo >= r_start_high && cur < hi_ext) begin
                                n_phase = lcer_pkg::PH_RAISE;
                                n_step  = (step_up > hi_ext) ? hi_ext[5:0] : step_up[5:0];
                                changed = 1'b1;
                            end else if (expo <= r_start_low && cur > lo_ext) begin
                                n_phase = lcer_pkg::PH_LOWER;
                                n_step  = (cur <= lo_plus) ? lo_ext[5:0] : step_dn[5:0];
                                changed = 1'b1;
                            end else begin
                                n_phase = lcer_pkg::PH_IDLE;
                            end
                        end
                    end
                    lcer_pkg::PH_RAISE: begin
                        if (expo > r_keep_high) begin
                            changed = 1'b1;
                            if (step_up >= hi_ext) begin
                                n_phase = lcer_pkg::PH_IDLE;
                                n_step  = hi_ext[5:0];
                            end else begin
                                n_step  = step_up[5:0];
                            end
                        end else begin
                            n_phase = lcer_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        // lowering, and the unused phase code
                        if (expo < r_keep_low) begin
                            changed = 1'b1;
                            if (cur <= lo_plus) begin
                                n_phase = lcer_pkg::PH_IDLE;
                                n_step  = lo_ext[5:0];
                            end else begin
                                n_phase = lcer_pkg::PH_LOWER;
                                n_step  = step_dn[5:0];
                            end
                        end else begin
                            n_phase = lcer_pkg::PH_IDLE;
                        end
                    end
                endcase
                if (changed) begin
                    n_out.led_write = 1'b1;
                    n_out.led_value = lcer_pkg::LED_DRIVE_BASE | {3'd0, n_step[4:0]};
                end
            end
        end else begin
            n_step          = {1'b0, DEFAULT_STEP};
            n_asleep        = 1'b1;
            n_out.led_write = 1'b1;
            n_out.led_value = lcer_pkg::LED_RELEASED;
        end
        n_out.current_changed = changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= 8'd3;
            r_start_high  <= 10'd800;
            r_start_low   <= 10'd200;
            r_keep_high   <= 10'd600;
            r_keep_low    <= 10'd400;
            r_cur_high    <= 5'd31;
            r_cur_low     <= 5'd0;
            r_step_inc    <= 5'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcer_pkg::CFG_FRAME_LIMIT: r_frame_limit <= i_cfg_data[7:0];
                lcer_pkg::CFG_START_HIGH:  r_start_high  <= i_cfg_data;
                lcer_pkg::CFG_START_LOW:   r_start_low   <= i_cfg_data;
                lcer_pkg::CFG_KEEP_HIGH:   r_keep_high   <= i_cfg_data;
                lcer_pkg::CFG_KEEP_LOW:    r_keep_low    <= i_cfg_data;
                lcer_pkg::CFG_CUR_HIGH:    r_cur_high    <= i_cfg_data[4:0];
                lcer_pkg::CFG_CUR_LOW:     r_cur_low     <= i_cfg_data[4:0];
                lcer_pkg::CFG_STEP_INC:    r_step_inc    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lcer_pkg::PH_IDLE;
            r_frame_cnt <= 8'd0;
            r_step      <= {1'b0, DEFAULT_STEP};
            r_asleep    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_frame_cnt <= n_frame_cnt;
                r_step      <= n_step;
                r_asleep    <= n_asleep;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== bench/led_drive_check_pkg.sv =====
// Frame-by-frame predictor and result checker for the LED current regulator bench.
// Depends on lcer_pkg for phase codes, register indexes and the result layout.
package led_drive_check_pkg;

    import lcer_pkg::*;

    localparam logic [4:0] DRIVE_DEFAULT = 5'd8;

    class led_drive_tracker;
        // register copies
        logic [7:0] frame_limit;
        logic [9:0] start_high;
        logic [9:0] start_low;
        logic [9:0] keep_high;
        logic [9:0] keep_low;
        logic [4:0] cur_high;
        logic [4:0] cur_low;
        logic [4:0] step_inc;
        // regulator state
        logic [1:0] reg_phase;
        logic [7:0] frame_cnt;
        logic [5:0] drive_step;
        bit         asleep;

        t_result    led_results_due[$];
        int         errors;
        int         frames_checked;
        int         led_writes;
        int         step_changes;

        function new();
            frame_limit = 8'd3;
            start_high = 10'd800;
            start_low = 10'd200;
            keep_high = 10'd600;
            keep_low = 10'd400;
            cur_high = 5'd31;
            cur_low = 5'd0;
            step_inc = 5'd2;
            reg_phase = PH_IDLE;
            frame_cnt = 8'd0;
            drive_step = {1'b0, DRIVE_DEFAULT};
            asleep = 1'b1;
            errors = 0;
            frames_checked = 0;
            led_writes = 0;
            step_changes = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [9:0] val);
            case (idx)
                CFG_FRAME_LIMIT: frame_limit = val[7:0];
                CFG_START_HIGH:  start_high = val;
                CFG_START_LOW:   start_low = val;
                CFG_KEEP_HIGH:   keep_high = val;
                CFG_KEEP_LOW:    keep_low = val;
                CFG_CUR_HIGH:    cur_high = val[4:0];
                CFG_CUR_LOW:     cur_low = val[4:0];
                CFG_STEP_INC:    step_inc = val[4:0];
                default: ;
            endcase
        endfunction

        // Advance the regulator by one accepted frame and queue its result.
        function void note_frame(input logic [7:0] touch, input logic [9:0] expo);
            t_result     r;
            int unsigned s;
            int unsigned hi;
            int unsigned lo;
            int unsigned inc;
            r = '0;
            hi = 32'(cur_high);
            lo = 32'(cur_low);
            inc = 32'(step_inc);
            s = 32'(drive_step);
            if (touch == TOUCH_PRESENT) begin
                r.sensor_active = 1'b1;
                if (asleep) begin
                    r.led_write = 1'b1;
                    r.led_value = LED_DRIVE_BASE | {3'b0, DRIVE_DEFAULT};
                    asleep = 1'b0;
                end
                if (frame_cnt <= frame_limit) begin
                    frame_cnt = frame_cnt + 8'd1;
                end else begin
                    frame_cnt = 8'd0;
                    case (reg_phase)
                        PH_IDLE: begin
                            if (expo >= start_high || expo <= start_low) begin
                                // decision starts from the register readback
                                s = s & 32'h1F;
                                if (expo >= start_high && s < hi) begin
                                    reg_phase = PH_RAISE;
                                    s = s + inc;
                                    if (s > hi)
                                        s = hi;
                                    r.current_changed = 1'b1;
                                end else if (expo <= start_low && s > lo) begin
                                    reg_phase = PH_LOWER;
                                    if (s <= lo + inc)
                                        s = lo;
                                    else
                                        s = s - inc;
                                    r.current_changed = 1'b1;
                                end else begin
                                    reg_phase = PH_IDLE;
                                end
                            end
                        end
                        PH_RAISE: begin
                            if (expo > keep_high) begin
                                s = s + inc;
                                if (s >= hi) begin
                                    reg_phase = PH_IDLE;
                                    s = hi;
                                end
                                r.current_changed = 1'b1;
                            end else begin
                                reg_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            // unused code falls in here with lowering
                            if (expo < keep_low) begin
                                reg_phase = PH_LOWER;
                                if (s <= lo + inc) begin
                                    reg_phase = PH_IDLE;
                                    s = lo;
                                end else begin
                                    s = s - inc;
                                end
                                r.current_changed = 1'b1;
                            end else begin
                                reg_phase = PH_IDLE;
                            end
                        end
                    endcase
                    drive_step = s[5:0];
                    if (r.current_changed) begin
                        r.led_write = 1'b1;
                        r.led_value = LED_DRIVE_BASE | {3'b0, drive_step[4:0]};
                    end
                end
            end else begin
                drive_step = {1'b0, DRIVE_DEFAULT};
                asleep = 1'b1;
                r.led_write = 1'b1;
                r.led_value = LED_RELEASED;
            end
            led_results_due.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (led_results_due.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            want = led_results_due.pop_front();
            frames_checked++;
            led_writes += int'(want.led_write);
            step_changes += int'(want.current_changed);
            if (got.led_write !== want.led_write) begin
                $error("led_write: expected %0d, got %0d", want.led_write, got.led_write);
                errors++;
            end
            if (got.led_value !== want.led_value) begin
                $error("led_value: expected %h, got %h", want.led_value, got.led_value);
                errors++;
            end
            if (got.current_changed !== want.current_changed) begin
                $error("current_changed: expected %0d, got %0d",
                       want.current_changed, got.current_changed);
                errors++;
            end
            if (got.sensor_active !== want.sensor_active) begin
                $error("sensor_active: expected %0d, got %0d",
                       want.sensor_active, got.sensor_active);
                errors++;
            end
        endfunction

        function int pending();
            return led_results_due.size();
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for led_current_exposure_regulator: drives frame items and register
// writes, checks every result against led_drive_check_pkg. Depends on lcer_pkg and led_drive_check_pkg.
module tb_top;

    import lcer_pkg::*;
    import led_drive_check_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AT = 300;       // result count at which the sink holds off
    localparam int HOLD_CYCLES = 150;
    localparam int DIRECTED_N = 25;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    led_drive_tracker board;
    bit tx_burst;
    bit rx_burst;
    int settings_used;
    int results_taken;
    int cycle_count;

    // directed frames: release codes, wake, raise to ceiling, lower to floor, hold bands
    logic [7:0] dir_touch [DIRECTED_N] = '{
        8'h00, 8'hFF, 8'h7F, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
        8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
        8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
    logic [9:0] dir_expo [DIRECTED_N] = '{
        10'd0, 10'd1023, 10'd512, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
        10'd500, 10'd500, 10'd850, 10'd850, 10'd500, 10'd500, 10'd0};

    led_current_exposure_regulator #(
        .DEFAULT_STEP(DRIVE_DEFAULT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, board.pending());
                $display("FAIL led_current_exposure_regulator");
                $finish;
            end
        end
    end

    // result sink: random stall per item outside receive bursts, one long hold-off to back up the input
    initial begin : result_sink
        int      stall;
        t_result got;
        results_taken = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (results_taken == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = m_axis_tdata[10:0];
            board.check_result(got);
            results_taken++;
        end
    end

    task automatic send_frame(input logic [7:0] touch, input logic [9:0] expo);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, expo, touch};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_frame(touch, expo);
    endtask

    task automatic end_frames();
        s_axis_tvalid <= 1'b0;
    endtask

    // all results in, plus the output register stage
    task automatic settle();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] frame_limit,
                                input logic [9:0] start_high, input logic [9:0] start_low,
                                input logic [9:0] keep_high, input logic [9:0] keep_low,
                                input logic [4:0] cur_high, input logic [4:0] cur_low,
                                input logic [4:0] step_inc);
        logic [9:0] vals [8];
        logic [2:0] idx [8];
        int k;
        settle();
        vals = '{{2'b0, frame_limit}, start_high, start_low, keep_high, keep_low,
                 {5'b0, cur_high}, {5'b0, cur_low}, {5'b0, step_inc}};
        idx = '{CFG_FRAME_LIMIT, CFG_START_HIGH, CFG_START_LOW, CFG_KEEP_HIGH,
                CFG_KEEP_LOW, CFG_CUR_HIGH, CFG_CUR_LOW, CFG_STEP_INC};
        for (k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.set_reg(idx[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly touched frames so the counter reaches decisions; exposure is
    // often placed within two of one of the four thresholds.
    task automatic random_frame(input int touch_pct);
        logic [7:0] touch;
        logic [9:0] expo;
        int         pick;
        int         around;
        if ($urandom_range(0, 99) < touch_pct) begin
            touch = TOUCH_PRESENT;
        end else begin
            do touch = 8'($urandom_range(0, 255)); while (touch == TOUCH_PRESENT);
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    around = int'(board.start_high);
            2, 3:    around = int'(board.start_low);
            4:       around = int'(board.keep_high);
            5:       around = int'(board.keep_low);
            default: around = -1;
        endcase
        if (around < 0) begin
            expo = 10'($urandom_range(0, 1023));
        end else begin
            around = around + int'($urandom_range(0, 4)) - 2;
            if (around < 0)
                around = 0;
            if (around > 1023)
                around = 1023;
            expo = around[9:0];
        end
        send_frame(touch, expo);
    endtask

    task automatic run_phase(input int n_items, input int touch_pct);
        int n;
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        for (n = 0; n < n_items; n++)
            random_frame(touch_pct);
        end_frames();
    endtask

    initial begin : stimulus
        int n;
        board = new();
        settings_used = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // decision every other frame, narrow limits, coarse increment
        program_regs(8'd0, 10'd800, 10'd200, 10'd600, 10'd400, 5'd20, 5'd3, 5'd7);
        for (n = 0; n < DIRECTED_N; n++)
            send_frame(dir_touch[n], dir_expo[n]);
        end_frames();

        program_regs(8'd3, 10'd800, 10'd200, 10'd600, 10'd400, 5'd31, 5'd0, 5'd2);
        run_phase(120, 85);
        // every exposure triggers, full swing per adjustment
        program_regs(8'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 5'd31, 5'd0, 5'd31);
        run_phase(100, 85);
        // floor above ceiling, zero increment
        program_regs(8'd1, 10'd1023, 10'd0, 10'd1023, 10'd0, 5'd0, 5'd31, 5'd0);
        run_phase(80, 85);
        // counter never passes the limit, never decides
        program_regs(8'd255, 10'd700, 10'd300, 10'd500, 10'd450, 5'd25, 5'd4, 5'd3);
        run_phase(50, 85);
        // longest real interval: one decision per 256 touched frames
        program_regs(8'd254, 10'd512, 10'd511, 10'd0, 10'd1023, 5'd31, 5'd0, 5'd5);
        run_phase(260, 98);
        for (n = 0; n < 3; n++) begin
            program_regs(8'($urandom_range(0, 6)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)), 5'($urandom_range(0, 31)),
                         5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            run_phase(100, 85);
        end

        settle();
        $display("%0d frame results checked under %0d register settings", board.frames_checked,
                 settings_used);
        $display("%0d LED register writes, %0d drive step changes", board.led_writes,
                 board.step_changes);
        if (board.errors == 0) begin
            $display("PASS led_current_exposure_regulator");
        end else begin
            $display("FAIL led_current_exposure_regulator");
        end
        $finish;
    end

endmodule
